### rtl/core/assert_macros.svh
// Assertion macros shared by the pulse finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every rising edge of clk_i outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never be seen on a rising edge of clk_i outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

### rtl/core/apf_pkg.sv
// Types and constants of the island pulse finder.
`timescale 1ns / 1ps
`default_nettype none
package apf_pkg;

  parameter int SAMPLE_BITS   = 12;
  parameter int POSITION_BITS = 16;
  parameter int TIME_BITS     = 32;
  parameter int COUNT_BITS    = 8;
  parameter int CFG_IDX_BITS  = 2;
  parameter int JUDGE_BITS    = 2;
  parameter int NUM_TAPS      = 3;
  parameter int JOB_DEPTH     = 4;
  parameter int JOB_PTR_BITS  = $clog2(JOB_DEPTH);
  parameter int JOB_CNT_BITS  = $clog2(JOB_DEPTH + 1);

  // Threshold sums and the scaled mean comparison.
  parameter int TH_BITS  = SAMPLE_BITS + 1;
  parameter int SUM_BITS = SAMPLE_BITS + 2;
  parameter int CMP_BITS = SAMPLE_BITS + 4;

  parameter logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  parameter logic [CFG_IDX_BITS-1:0] REG_PEDESTAL  = CFG_IDX_BITS'(0);
  parameter logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = CFG_IDX_BITS'(1);
  parameter logic [CFG_IDX_BITS-1:0] REG_NOISE_RMS = CFG_IDX_BITS'(2);
  parameter logic [CFG_IDX_BITS-1:0] REG_POLARITY  = CFG_IDX_BITS'(3);

  parameter logic KIND_PULSE   = 1'b0;
  parameter logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   island_start;
    logic                   island_end;
    logic [TIME_BITS-1:0]   island_time;
  } apf_in_t;

  typedef struct packed {
    logic                   kind;
    logic [TIME_BITS-1:0]   pulse_time;
    logic [SAMPLE_BITS-1:0] pulse_sample;
    logic                   pulse_last;
    logic [COUNT_BITS-1:0]  pulse_count;
  } apf_out_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] pedestal;
    logic [SAMPLE_BITS-1:0] threshold;
    logic [SAMPLE_BITS-1:0] noise_rms;
    logic                   polarity;
  } apf_cfg_t;

  // One accepted sample turned into work for the back end: clear the
  // pulse state, run njudge judgements over the taps, then summarize.
  typedef struct packed {
    logic                                  clr;
    logic                                  summary;
    logic [JUDGE_BITS-1:0]                 njudge;
    logic [NUM_TAPS-1:0][SAMPLE_BITS-1:0]  taps;
    logic [POSITION_BITS-1:0]              idx;
    logic [TIME_BITS-1:0]                  base;
  } apf_job_t;

  typedef struct packed {
    logic push;
    logic full;
  } apf_wr_t;

endpackage
`default_nettype wire

### rtl/core/adc_island_pulse_finder.sv
// Top level of the island pulse finder: configuration registers and wiring.
//
//   channel   direction  handshake              payload
//   input     in         push / full            in_data_i   (apf_in_t)
//   result    out        pop / empty            res_data_o  (apf_out_t)
//   config    in         cfg_valid_i / _ready_o cfg_index_i, cfg_data_i
//
// One sample is taken every cycle while the job queue (4 deep) has room.
// The back end runs one lookahead judgement per cycle and one result per
// cycle; a judgement that also releases a pulse's held first sample takes
// an extra release step, and an island end costs up to three judgements,
// two releases and the summary. A result waiting on pop holds the back end,
// and the queue then fills and raises full.
// Reset clears all control state; cfg_ready_o is always high.
`timescale 1ns / 1ps
`default_nettype none
module adc_island_pulse_finder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  apf_pkg::apf_in_t                    in_data_i,
  output logic                                empty,
  input  logic                                pop,
  output apf_pkg::apf_out_t                   res_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [apf_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [apf_pkg::SAMPLE_BITS-1:0]     cfg_data_i
);
  import apf_pkg::*;

  apf_cfg_t cfg_q;
  apf_job_t job_in, job_out;
  apf_wr_t  wr;
  logic     accept, job_push, job_empty, job_pop, res_valid;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;
  assign full        = wr.full;
  assign empty       = !res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pedestal  <= '0;
      cfg_q.threshold <= '0;
      cfg_q.noise_rms <= '0;
      cfg_q.polarity  <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PEDESTAL:  cfg_q.pedestal  <= cfg_data_i;
        REG_THRESHOLD: cfg_q.threshold <= cfg_data_i;
        REG_NOISE_RMS: cfg_q.noise_rms <= cfg_data_i;
        REG_POLARITY:  cfg_q.polarity  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  apf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_data_i),
    .accept_i   (accept),
    .job_o      (job_in),
    .job_push_o (job_push)
  );

  apf_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .wr_o    (wr),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  apf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .res_o       (res_data_o),
    .res_valid_o (res_valid),
    .res_pop_i   (pop && res_valid)
  );

endmodule
`default_nettype wire

### rtl/core/apf_front.sv
// Front end: lookahead window, island bookkeeping and job building.
`timescale 1ns / 1ps
`default_nettype none
module apf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  apf_pkg::apf_in_t  in_i,
  input  logic              accept_i,
  output apf_pkg::apf_job_t job_o,
  output logic              job_push_o
);
  import apf_pkg::*;

  localparam logic [1:0] FILL_EMPTY = 2'd0;
  localparam logic [1:0] FILL_ONE   = 2'd1;
  localparam logic [1:0] FILL_FULL  = 2'd2;

  logic [SAMPLE_BITS-1:0]   win0_q, win1_q, win0_d, win1_d;
  logic [1:0]               fill_q, fill_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [TIME_BITS-1:0]     base_q, base_d;
  logic                     stopped_q, stopped_d;

  logic [1:0]               fill_eff;
  logic [POSITION_BITS-1:0] pos_eff;
  logic                     stop_eff;
  logic [SAMPLE_BITS-1:0]   smp;
  logic [JUDGE_BITS-1:0]    njudge;

  always_comb begin
    // a new island drops whatever the old one left behind
    fill_eff = in_i.island_start ? FILL_EMPTY : fill_q;
    pos_eff  = in_i.island_start ? '0 : pos_q;
    stop_eff = in_i.island_start ? 1'b0 : stopped_q;
    base_d   = in_i.island_start ? in_i.island_time : base_q;
    smp      = stop_eff ? '0 : in_i.sample;

    job_o.taps = '0;
    win0_d     = win0_q;
    win1_d     = win1_q;
    unique case (fill_eff)
      FILL_EMPTY: begin
        job_o.taps[0] = smp;
        njudge        = in_i.island_end ? JUDGE_BITS'(1) : '0;
        win0_d        = smp;
        fill_d        = FILL_ONE;
      end
      FILL_ONE: begin
        job_o.taps[0] = win0_q;
        job_o.taps[1] = smp;
        njudge        = in_i.island_end ? JUDGE_BITS'(2) : '0;
        win1_d        = smp;
        fill_d        = FILL_FULL;
      end
      default: begin
        job_o.taps[0] = win0_q;
        job_o.taps[1] = win1_q;
        job_o.taps[2] = smp;
        njudge        = in_i.island_end ? JUDGE_BITS'(3) : JUDGE_BITS'(1);
        win0_d        = win1_q;
        win1_d        = smp;
        fill_d        = FILL_FULL;
      end
    endcase

    pos_d     = pos_eff + POSITION_BITS'(njudge);
    stopped_d = stop_eff || (smp == '0);
    if (in_i.island_end) begin
      fill_d    = FILL_EMPTY;
      pos_d     = '0;
      win0_d    = '0;
      win1_d    = '0;
      stopped_d = 1'b1;
    end

    job_o.clr     = in_i.island_start;
    job_o.summary = in_i.island_end;
    job_o.njudge  = njudge;
    job_o.idx     = pos_eff;
    job_o.base    = base_d;
    job_push_o    = accept_i && ((njudge != '0) || in_i.island_start || in_i.island_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win0_q    <= '0;
      win1_q    <= '0;
      fill_q    <= FILL_EMPTY;
      pos_q     <= '0;
      base_q    <= '0;
      stopped_q <= 1'b0;
    end else if (accept_i) begin
      win0_q    <= win0_d;
      win1_q    <= win1_d;
      fill_q    <= fill_d;
      pos_q     <= pos_d;
      base_q    <= base_d;
      stopped_q <= stopped_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/apf_job_fifo.sv
// Job queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module apf_job_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  apf_pkg::apf_job_t data_i,
  output apf_pkg::apf_wr_t  wr_o,
  input  logic              pop_i,
  output apf_pkg::apf_job_t data_o,
  output logic              empty_o
);
  import apf_pkg::*;

  apf_job_t                mem_q [JOB_DEPTH];
  logic [JOB_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [JOB_CNT_BITS-1:0] cnt_q;
  logic                    do_push, do_pop;

  assign wr_o.full = (cnt_q == JOB_CNT_BITS'(JOB_DEPTH));
  assign wr_o.push = do_push;
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !wr_o.full;
  assign do_pop    = pop_i && !empty_o;
  assign data_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + JOB_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + JOB_PTR_BITS'(1);
      end
      cnt_q <= cnt_q + JOB_CNT_BITS'(do_push) - JOB_CNT_BITS'(do_pop);
    end
  end

  `ASSERT_NEVER(a_fifo_overfill, cnt_q > JOB_CNT_BITS'(JOB_DEPTH), "job queue count overflow")
  `ASSERT_NEVER(a_fifo_push_full, push_i && wr_o.full, "front end pushed into a full queue")
  `ASSERT_NEVER(a_fifo_pop_empty, pop_i && empty_o, "back end popped an empty queue")
  `ASSERT_CLK(a_fifo_ptrs, (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q), "pointers disagree when empty")

endmodule
`default_nettype wire

### rtl/core/apf_back.sv
// Back end: pulse judgement, emission sequencing and the result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module apf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  apf_pkg::apf_cfg_t cfg_i,
  input  apf_pkg::apf_job_t job_i,
  input  logic              job_empty_i,
  output logic              job_pop_o,
  output apf_pkg::apf_out_t res_o,
  output logic              res_valid_o,
  input  logic              res_pop_i
);
  import apf_pkg::*;

  localparam logic [1:0] PLEN_NONE = 2'd0;
  localparam logic [1:0] PLEN_ONE  = 2'd1;
  localparam logic [1:0] PLEN_MORE = 2'd2;

  logic [JUDGE_BITS-1:0]  k_q, k_d;
  logic                   phase_q, phase_d;
  logic                   in_pulse_q, in_pulse_d;
  logic [1:0]             plen_q, plen_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic [TIME_BITS-1:0]   start_q, start_d;
  logic [SAMPLE_BITS-1:0] held_q;
  logic                   held_we;
  apf_out_t               out_q, out_d;
  logic                   out_valid_q;

  logic                     fresh, clear_now, ip_cur;
  logic [1:0]               plen_cur, plen_eff;
  logic [COUNT_BITS-1:0]    cnt_cur, cnt_inc;
  logic [SAMPLE_BITS-1:0]   cur, nx, nx2;
  logic                     is_judge, nz, hit, go, act, ends, two_phase;
  logic [TH_BITS-1:0]       up_lvl, nx_thr;
  logic [SUM_BITS-1:0]      sum;
  logic signed [CMP_BITS-1:0] sum_s, lo_s, hi_s, lo3_s, hi3_s;
  logic [POSITION_BITS-1:0] idx;
  logic [TIME_BITS-1:0]     st;
  logic                     emit, out_ready, step_go, last_step;

  always_comb begin
    unique case (k_q)
      2'd0: begin
        cur = job_i.taps[0];
        nx  = job_i.taps[1];
        nx2 = job_i.taps[2];
      end
      2'd1: begin
        cur = job_i.taps[1];
        nx  = job_i.taps[2];
        nx2 = '0;
      end
      2'd2: begin
        cur = job_i.taps[2];
        nx  = '0;
        nx2 = '0;
      end
      default: begin
        cur = '0;
        nx  = '0;
        nx2 = '0;
      end
    endcase
  end

  always_comb begin
    // the island clear of a job applies before its first judgement
    fresh     = (k_q == '0) && !phase_q;
    clear_now = fresh && job_i.clr;
    ip_cur    = clear_now ? 1'b0 : in_pulse_q;
    plen_cur  = clear_now ? PLEN_NONE : plen_q;
    cnt_cur   = clear_now ? '0 : cnt_q;
    cnt_inc   = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);

    is_judge = (k_q < job_i.njudge);
    nz       = (cur != '0);

    up_lvl = TH_BITS'(cfg_i.pedestal) + TH_BITS'(cfg_i.threshold);
    nx_thr = TH_BITS'(nx) + TH_BITS'(cfg_i.threshold);
    if (cfg_i.polarity) begin
      hit = (cur > cfg_i.pedestal) && (TH_BITS'(nx) > up_lvl);
    end else begin
      hit = (cur < cfg_i.pedestal) && (nx_thr < TH_BITS'(cfg_i.pedestal));
    end
    go  = nz && !ip_cur && hit;
    act = nz && (ip_cur || go);

    // floor(sum/3) < p  <=>  sum < 3p ;  floor(sum/3) > q  <=>  sum >= 3(q+1)
    sum   = SUM_BITS'(cur) + SUM_BITS'(nx) + SUM_BITS'(nx2);
    sum_s = signed'(CMP_BITS'(sum));
    lo_s  = signed'(CMP_BITS'(cfg_i.pedestal)) - signed'(CMP_BITS'(cfg_i.noise_rms));
    hi_s  = signed'(CMP_BITS'(cfg_i.pedestal)) + signed'(CMP_BITS'(cfg_i.noise_rms))
          + signed'(CMP_BITS'(1));
    lo3_s = lo_s + (lo_s <<< 1);
    hi3_s = hi_s + (hi_s <<< 1);
    ends  = (nx == '0) || (cfg_i.polarity ? (sum_s < lo3_s) : (sum_s >= hi3_s));

    idx      = job_i.idx + POSITION_BITS'(k_q);
    st       = go ? (job_i.base + TIME_BITS'(idx)) : start_q;
    plen_eff = go ? PLEN_NONE : plen_cur;

    two_phase = is_judge && act && (plen_eff == PLEN_ONE);
    emit      = is_judge ? (act && (plen_eff != PLEN_NONE)) : job_i.summary;
    out_ready = !out_valid_q || res_pop_i;
    step_go   = !job_empty_i && (!emit || out_ready);
    last_step = is_judge ? ((k_q + JUDGE_BITS'(1) == job_i.njudge) && !job_i.summary) : 1'b1;

    out_d.kind         = is_judge ? KIND_PULSE : KIND_SUMMARY;
    out_d.pulse_time   = is_judge ? st : '0;
    out_d.pulse_sample = is_judge ? (two_phase ? held_q : cur) : '0;
    out_d.pulse_last   = is_judge && !two_phase && ends;
    out_d.pulse_count  = is_judge ? '0 : cnt_cur;

    in_pulse_d = ip_cur;
    plen_d     = plen_cur;
    cnt_d      = cnt_cur;
    start_d    = start_q;
    held_we    = 1'b0;
    if (is_judge) begin
      if (act) begin
        start_d = st;
        unique case (plen_eff)
          PLEN_NONE: begin
            held_we    = 1'b1;
            in_pulse_d = !ends;
            plen_d     = ends ? PLEN_NONE : PLEN_ONE;
          end
          PLEN_ONE: begin
            // release the held first sample; this one is judged on the following step
            in_pulse_d = 1'b1;
            plen_d     = PLEN_MORE;
          end
          default: begin
            in_pulse_d = !ends;
            plen_d     = ends ? PLEN_NONE : PLEN_MORE;
            cnt_d      = ends ? cnt_inc : cnt_cur;
          end
        endcase
      end
    end else if (job_i.summary) begin
      in_pulse_d = 1'b0;
      plen_d     = PLEN_NONE;
      cnt_d      = '0;
    end

    phase_d   = two_phase;
    job_pop_o = step_go && !two_phase && last_step;
    if (two_phase) begin
      k_d = k_q;
    end else if (last_step) begin
      k_d = '0;
    end else begin
      k_d = k_q + JUDGE_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      phase_q     <= 1'b0;
      in_pulse_q  <= 1'b0;
      plen_q      <= PLEN_NONE;
      cnt_q       <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step_go) begin
        k_q        <= k_d;
        phase_q    <= phase_d;
        in_pulse_q <= in_pulse_d;
        plen_q     <= plen_d;
        cnt_q      <= cnt_d;
        start_q    <= start_d;
      end
      if (step_go && emit) begin
        out_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go && held_we) begin
      held_q <= cur;
    end
    if (step_go && emit) begin
      out_q <= out_d;
    end
  end

  assign res_o       = out_q;
  assign res_valid_o = out_valid_q;

  `ASSERT_CLK(a_back_phase_job, phase_q |-> !job_empty_i, "release phase without a job")
  `ASSERT_CLK(a_back_step_job, (k_q != '0) |-> !job_empty_i, "mid-job step without a job")
  `ASSERT_CLK(a_back_plen_pulse, (plen_q != PLEN_NONE) |-> in_pulse_q, "length outside a pulse")
  `ASSERT_CLK(a_back_phase_one, phase_q |-> (plen_q == PLEN_MORE), "release phase with wrong length")

endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench of the island pulse finder: stimulus, result prediction and checking.
`timescale 1ns / 1ps
module testbench;
  import apf_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_CYCLES  = 300;
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int MEAN_TAPS     = 3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  apf_in_t in_data_i = '0;
  logic empty;
  logic pop = 1'b0;
  apf_out_t res_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [SAMPLE_BITS-1:0] cfg_data_i = '0;

  adc_island_pulse_finder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .res_data_o (res_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies and island state of the finder as predicted.
  logic [SAMPLE_BITS-1:0]   cfg_ped = '0;
  logic [SAMPLE_BITS-1:0]   cfg_thr = '0;
  logic [SAMPLE_BITS-1:0]   cfg_rms = '0;
  logic                     cfg_pos = 1'b1;
  logic [SAMPLE_BITS-1:0]   win_a = '0;
  logic [SAMPLE_BITS-1:0]   win_b = '0;
  int                       win_fill = 0;
  bit                       in_pulse = 1'b0;
  int                       pulse_len = 0;
  logic [SAMPLE_BITS-1:0]   first_sample = '0;
  logic [TIME_BITS-1:0]     pulse_t0 = '0;
  logic [POSITION_BITS-1:0] sample_idx = '0;
  logic [TIME_BITS-1:0]     island_t0 = '0;
  bit                       island_done = 1'b0;
  logic [COUNT_BITS-1:0]    pulse_tally = '0;

  apf_in_t  feed[$];
  apf_out_t awaited[$];
  int       fault_count = 0;
  int       items_added = 0;
  int unsigned cycle_count = 0;

  // Sender and receiver pacing.
  int gap_left = 0;
  int burst_left = 4;
  bit tx_steady = 1'b0;
  bit stall_req = 1'b0;
  bit stall_ack = 1'b0;
  int stall_left = 0;
  logic [15:0] rx_mask = 16'hFFFF;
  int rx_turns = 0;

  function automatic void add_result(logic kind, logic [TIME_BITS-1:0] t,
                                     logic [SAMPLE_BITS-1:0] s, logic last,
                                     logic [COUNT_BITS-1:0] cnt);
    apf_out_t r;
    r.kind = kind;
    r.pulse_time = t;
    r.pulse_sample = s;
    r.pulse_last = last;
    r.pulse_count = cnt;
    awaited.insert(awaited.size(), r);
  endfunction

  function automatic void reset_island();
    win_a = '0;
    win_b = '0;
    win_fill = 0;
    in_pulse = 1'b0;
    pulse_len = 0;
    sample_idx = '0;
    pulse_tally = '0;
  endfunction

  // Judge one sample against the two that follow it.
  function automatic void judge_window(logic [SAMPLE_BITS-1:0] cur,
                                       logic [SAMPLE_BITS-1:0] nx,
                                       logic [SAMPLE_BITS-1:0] nx2);
    logic [POSITION_BITS-1:0] at;
    int c, a, b, ped, thr, rms, avg;
    bit ends;
    at = sample_idx;
    sample_idx = sample_idx + 1'b1;
    if (cur == 0) return;
    c = cur;
    a = nx;
    b = nx2;
    ped = cfg_ped;
    thr = cfg_thr;
    rms = cfg_rms;
    if (!in_pulse) begin
      if (cfg_pos ? (c > ped && a > ped + thr) : (c < ped && a < ped - thr)) begin
        in_pulse = 1'b1;
        pulse_len = 0;
        pulse_t0 = island_t0 + TIME_BITS'(at);
      end
    end
    if (!in_pulse) return;
    if (nx == 0) begin
      ends = 1'b1;
    end else begin
      avg = (c + a + b) / MEAN_TAPS;
      ends = cfg_pos ? (avg < ped - rms) : (avg > ped + rms);
    end
    if (pulse_len == 0) begin
      first_sample = cur;
      pulse_len = 1;
    end else begin
      if (pulse_len == 1) add_result(KIND_PULSE, pulse_t0, first_sample, 1'b0, '0);
      add_result(KIND_PULSE, pulse_t0, cur, ends, '0);
      pulse_len = 2;
      if (ends && pulse_tally != COUNT_MAX) pulse_tally = pulse_tally + 1'b1;
    end
    if (ends) begin
      in_pulse = 1'b0;
      pulse_len = 0;
    end
  endfunction

  function automatic void take_sample(apf_in_t it);
    logic [SAMPLE_BITS-1:0] s;
    s = it.sample;
    if (it.island_start) begin
      reset_island();
      island_t0 = it.island_time;
      island_done = 1'b0;
    end
    if (island_done) s = '0;
    if (s == 0) island_done = 1'b1;
    if (win_fill >= 2) begin
      judge_window(win_a, win_b, s);
      win_a = win_b;
      win_b = s;
    end else begin
      if (win_fill == 0) win_a = s;
      else win_b = s;
      win_fill++;
    end
    if (it.island_end) begin
      // Flush the lookahead with zeros past the end.
      if (win_fill >= 2) begin
        judge_window(win_a, win_b, '0);
        judge_window(win_b, '0, '0);
      end else if (win_fill == 1) begin
        judge_window(win_a, '0, '0);
      end
      add_result(KIND_SUMMARY, '0, '0, 1'b0, pulse_tally);
      reset_island();
      island_done = 1'b1;
    end
  endfunction

  function automatic void flag(string what, logic [TIME_BITS-1:0] want,
                               logic [TIME_BITS-1:0] got);
    fault_count++;
    if (fault_count <= 40)
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
  endfunction

  function automatic void check_result(apf_out_t got);
    apf_out_t want;
    if (awaited.size() == 0) begin
      fault_count++;
      if (fault_count <= 40)
        $display("%0t: result expected none got %h", $time, got);
      return;
    end
    want = awaited.pop_front();
    if (got.kind !== want.kind) flag("kind", want.kind, got.kind);
    if (got.pulse_time !== want.pulse_time) flag("pulse_time", want.pulse_time, got.pulse_time);
    if (got.pulse_sample !== want.pulse_sample)
      flag("pulse_sample", want.pulse_sample, got.pulse_sample);
    if (got.pulse_last !== want.pulse_last) flag("pulse_last", want.pulse_last, got.pulse_last);
    if (got.pulse_count !== want.pulse_count)
      flag("pulse_count", want.pulse_count, got.pulse_count);
  endfunction

  // Sample sender: offers the head of the feed in bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        take_sample(feed.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 10);
          if (!tx_steady) gap_left = $urandom_range(1, 12);
        end
      end else if (!push && gap_left > 0) begin
        gap_left--;
      end
      if (tx_steady) gap_left = 0;
      if (gap_left == 0 && feed.size() != 0) begin
        push <= 1'b1;
        in_data_i <= feed[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result receiver: checks each transfer, pops on a rotating mask.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result(res_data_o);
      if (stall_ack != stall_req) begin
        stall_ack = stall_req;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= rx_mask[0];
        rx_mask = {rx_mask[0], rx_mask[15:1]};
        rx_turns++;
        if (rx_turns == 16) begin
          rx_turns = 0;
          rx_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h1);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SAMPLE_BITS-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_PEDESTAL:  cfg_ped = val;
      REG_THRESHOLD: cfg_thr = val;
      REG_NOISE_RMS: cfg_rms = val;
      REG_POLARITY:  cfg_pos = val[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(int ped, int thr, int rms, bit pol);
    write_reg(REG_PEDESTAL, SAMPLE_BITS'(ped));
    write_reg(REG_THRESHOLD, SAMPLE_BITS'(thr));
    write_reg(REG_NOISE_RMS, SAMPLE_BITS'(rms));
    // upper bits of the polarity write are don't-care
    write_reg(REG_POLARITY, {11'($urandom()), pol});
    @(negedge clk_i);
  endtask

  // Wait until the feed is drained and every result is in, then let the block go quiet.
  task automatic settle();
    do @(negedge clk_i); while (feed.size() != 0 || push || awaited.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic void add_item(int s, bit st, bit en, logic [TIME_BITS-1:0] t);
    apf_in_t it;
    it.sample = SAMPLE_BITS'(s);
    it.island_start = st;
    it.island_end = en;
    it.island_time = t;
    feed.insert(feed.size(), it);
    items_added++;
  endfunction

  function automatic int shift_level(int off);
    int v;
    v = cfg_pos ? int'(cfg_ped) + off : int'(cfg_ped) - off;
    if (v < 1) v = 1;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  // Baseline noise around the pedestal with bumps past the threshold.
  function automatic void add_island(int len, bit with_end);
    logic [TIME_BITS-1:0] t0;
    int k, bump, v;
    t0 = $urandom();
    bump = 0;
    for (k = 0; k < len; k++) begin
      if (bump == 0 && $urandom_range(0, 4) == 0) bump = $urandom_range(1, 8);
      if (bump > 0) begin
        v = shift_level(int'(cfg_thr) + 1 + int'($urandom_range(0, 400)));
        bump--;
      end else begin
        v = shift_level(int'($urandom_range(0, 2 * cfg_rms + 120)) - int'(cfg_rms) - 100);
      end
      if ($urandom_range(0, 39) == 0) v = 0;
      add_item(v, k == 0, with_end && k == len - 1, (k == 0) ? t0 : $urandom());
    end
  endfunction

  function automatic void random_mix(int target);
    int first;
    first = items_added;
    while (items_added - first < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: add_island($urandom_range(2, 14), 1'b1);
        6: add_island($urandom_range(1, 6), 1'b0);
        7: add_item($urandom_range(0, 4095), $urandom_range(0, 5) == 0,
                    $urandom_range(0, 5) == 0, $urandom());
        8: add_island(1, 1'b1);
        default: add_item(0, 1'b0, 1'b1, $urandom());
      endcase
    end
  endfunction

  initial begin
    int k;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: any nonzero pair starts a pulse, only zeros end one.
    add_item(1, 1'b0, 1'b0, 32'h0);               // no island started yet
    add_item(4095, 1'b0, 1'b0, 32'h0);
    add_item(7, 1'b0, 1'b0, 32'h0);
    add_item(300, 1'b1, 1'b0, 32'hFFFF_FFFE);     // restart drops the open island
    add_item(200, 1'b0, 1'b0, 32'h0);
    add_item(4095, 1'b0, 1'b0, 32'h0);
    add_item(0, 1'b0, 1'b0, 32'h0);               // zero stops the island
    add_item(500, 1'b0, 1'b0, 32'h0);
    add_item(600, 1'b0, 1'b1, 32'h0);
    add_item(700, 1'b0, 1'b0, 32'hFFFF_FFFF);     // ignored after an end
    add_item(0, 1'b0, 1'b1, 32'h0);               // lone end
    add_item(123, 1'b1, 1'b1, 32'h5);             // one-sample island
    add_item(10, 1'b1, 1'b0, 32'h0);
    add_item(20, 1'b0, 1'b1, 32'h0);
    add_item(4095, 1'b1, 1'b0, 32'hFFFF_FFFF);
    add_item(4095, 1'b0, 1'b0, 32'h0);
    add_item(1, 1'b0, 1'b0, 32'h0);
    add_item(4095, 1'b0, 1'b0, 32'h0);
    add_item(4095, 1'b0, 1'b1, 32'h0);
    add_item(5, 1'b0, 1'b1, 32'h0);
    settle();

    set_config(2000, 100, 50, 1'b1);
    random_mix(20);
    settle();
    set_config(2000, 100, 50, 1'b0);
    random_mix(20);
    settle();
    set_config($urandom_range(0, 4095), $urandom_range(0, 600), $urandom_range(0, 600), 1'b1);
    random_mix(16);
    settle();
    set_config($urandom_range(0, 4095), $urandom_range(0, 600), $urandom_range(0, 600), 1'b0);
    random_mix(16);
    settle();

    // Register extremes.
    set_config(4095, 4095, 4095, 1'b0);
    random_mix(6);
    settle();
    set_config(0, 0, 0, 1'b0);
    random_mix(6);
    settle();
    set_config(4095, 0, 4095, 1'b0);
    random_mix(6);
    settle();
    set_config(0, 4095, 0, 1'b1);
    random_mix(6);
    settle();

    // Back up the results: one long pulse while the receiver holds off.
    set_config(1000, 10, 100, 1'b1);
    tx_steady = 1'b1;
    add_item(1500, 1'b1, 1'b0, $urandom());
    for (k = 1; k < 30; k++) add_item(1200 + $urandom_range(0, 2000), 1'b0, k == 29, $urandom());
    random_mix(8);
    stall_req = ~stall_req;
    settle();
    tx_steady = 1'b0;

    if (fault_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
